// File: sv/rap_pkg.sv
// shared types and constants for the radius attribute parser
`default_nettype none

package rap_pkg;

    localparam int MAX_ATTRIBUTES = 32;
    localparam int HEADER_BYTES   = 20;
    localparam int MIN_ATTR_LEN   = 2;

    typedef enum logic [2:0] {
        KIND_CODE       = 3'd0,
        KIND_IDENTIFIER = 3'd1,
        KIND_LENGTH     = 3'd2,
        KIND_AUTH       = 3'd3,
        KIND_ATTR_HDR   = 3'd4,
        KIND_ATTR_VALUE = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        STOP_RUNNING   = 2'd0,
        STOP_LENGTH    = 2'd1,
        STOP_TOO_MANY  = 2'd2,
        STOP_ZERO_TYPE = 2'd3
    } t_stop;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       packet_start;
    } t_in_beat;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] field_value;
        logic [15:0] byte_position;
        logic [6:0]  attr_number;
        logic [7:0]  attr_kind;
        logic [7:0]  attr_data_length;
        logic        attr_last_byte;
        logic        malformed_length;
        t_stop       stop_reason;
    } t_out_beat;

endpackage

`default_nettype wire

// File: sv/rap_parser.sv
// parse state machine: one byte in, at most one result out, same cycle
`default_nettype none

module rap_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire rap_pkg::t_in_beat  i_in,
    output logic                    o_res_valid,
    output rap_pkg::t_out_beat      o_res
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_TYPE   = 3'd2,
        PH_LEN    = 3'd3,
        PH_VALUE  = 3'd4
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [15:0] r_offset,   n_offset;
    logic [15:0] r_decl_len, n_decl_len;
    logic [6:0]  r_count,    n_count;
    logic [7:0]  r_left,     n_left;
    logic [7:0]  r_type,     n_type;
    logic        r_done,     n_done;
    logic [7:0]  r_dlen,     n_dlen;

    always_comb begin
        t_phase      ph;
        logic [15:0] pos;
        logic [15:0] decl;
        logic [6:0]  cnt;
        logic [7:0]  left;
        logic [7:0]  ctype;
        logic [7:0]  dlen;
        logic [7:0]  b;
        logic        go;
        logic        mal;
        logic        last;
        logic        check;
        rap_pkg::t_stop stop;

        n_phase    = r_phase;
        n_offset   = r_offset;
        n_decl_len = r_decl_len;
        n_count    = r_count;
        n_left     = r_left;
        n_type     = r_type;
        n_done     = r_done;
        n_dlen     = r_dlen;
        o_res_valid = 1'b0;
        o_res       = '0;

        b     = i_in.byte_value;
        go    = i_accept && (i_in.packet_start || (!r_done && r_phase != PH_IDLE));
        ph    = i_in.packet_start ? PH_HEADER : r_phase;
        pos   = i_in.packet_start ? 16'd0 : r_offset;
        decl  = i_in.packet_start ? 16'd0 : r_decl_len;
        cnt   = i_in.packet_start ? 7'd0  : r_count;
        left  = i_in.packet_start ? 8'd0  : r_left;
        ctype = i_in.packet_start ? 8'd0  : r_type;
        dlen  = i_in.packet_start ? 8'd0  : r_dlen;
        mal   = 1'b0;
        last  = 1'b0;
        check = 1'b0;
        stop  = rap_pkg::STOP_RUNNING;

        if (go) begin
            n_done     = 1'b0;
            n_phase    = ph;
            n_offset   = (pos != 16'hFFFF) ? pos + 16'd1 : pos;
            n_decl_len = decl;
            n_count    = cnt;
            n_left     = left;
            n_type     = ctype;
            n_dlen     = dlen;
            o_res.byte_position = pos;

            unique case (ph)
                PH_HEADER: begin
                    o_res_valid = 1'b1;
                    o_res.field_value = {8'd0, b};
                    check = (pos == 16'(rap_pkg::HEADER_BYTES - 1));
                    if (pos == 16'd0) begin
                        o_res.kind = rap_pkg::KIND_CODE;
                    end else if (pos == 16'd1) begin
                        o_res.kind = rap_pkg::KIND_IDENTIFIER;
                    end else if (pos == 16'd2) begin
                        n_decl_len  = {b, 8'd0};
                        o_res_valid = 1'b0;
                    end else if (pos == 16'd3) begin
                        n_decl_len = decl | {8'd0, b};
                        o_res.kind = rap_pkg::KIND_LENGTH;
                        o_res.field_value = decl | {8'd0, b};
                    end else begin
                        o_res.kind = rap_pkg::KIND_AUTH;
                    end
                end
                PH_TYPE: begin
                    if (b == 8'd0) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                        o_res_valid       = 1'b1;
                        o_res.kind        = rap_pkg::KIND_ATTR_HDR;
                        o_res.attr_number = cnt;
                        stop              = rap_pkg::STOP_ZERO_TYPE;
                    end else begin
                        n_type  = b;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    mal    = (b < 8'(rap_pkg::MIN_ATTR_LEN));
                    n_dlen = mal ? 8'd0 : b - 8'(rap_pkg::MIN_ATTR_LEN);
                    n_left = n_dlen;
                    if (n_dlen == 8'd0) begin
                        n_count = cnt + 7'd1;
                        check   = 1'b1;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                    o_res_valid = 1'b1;
                    o_res.kind  = rap_pkg::KIND_ATTR_HDR;
                    o_res.field_value      = {8'd0, b};
                    o_res.attr_number      = cnt;
                    o_res.attr_kind        = ctype;
                    o_res.attr_data_length = n_dlen;
                    o_res.malformed_length = mal;
                end
                PH_VALUE: begin
                    n_left = (left != 8'd0) ? left - 8'd1 : left;
                    last   = (n_left == 8'd0);
                    if (last) begin
                        n_count = cnt + 7'd1;
                        check   = 1'b1;
                    end
                    o_res_valid = 1'b1;
                    o_res.kind  = rap_pkg::KIND_ATTR_VALUE;
                    o_res.field_value      = {8'd0, b};
                    o_res.attr_number      = cnt;
                    o_res.attr_kind        = ctype;
                    o_res.attr_data_length = dlen;
                    o_res.attr_last_byte   = last;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            endcase

            // attribute boundary: length limit first, then attribute limit
            if (check) begin
                if (n_offset >= n_decl_len) begin
                    stop    = rap_pkg::STOP_LENGTH;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end else if (n_count >= 7'(rap_pkg::MAX_ATTRIBUTES)) begin
                    stop    = rap_pkg::STOP_TOO_MANY;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_phase = PH_TYPE;
                end
            end
            o_res.stop_reason = stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_offset   <= '0;
            r_decl_len <= '0;
            r_count    <= '0;
            r_left     <= '0;
            r_type     <= '0;
            r_done     <= 1'b1;
            r_dlen     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_offset   <= n_offset;
            r_decl_len <= n_decl_len;
            r_count    <= n_count;
            r_left     <= n_left;
            r_type     <= n_type;
            r_done     <= n_done;
            r_dlen     <= n_dlen;
        end
    end

endmodule

`default_nettype wire

// File: sv/radius_attribute_parser.sv
// top level: byte parser followed by a two-entry result queue
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------
//  in      | input     | i_in_valid / o_in_stall | rap_pkg::t_in_beat
//  out     | output    | o_out_valid / i_out_stall | rap_pkg::t_out_beat
//
// one byte is taken every cycle while o_in_stall is low; its result is registered
// in the output register, or in the skid entry while the output register is held
// the parse state updates in the cycle the byte is taken, so bytes may follow
// back to back; a result register plus a skid entry hold up to two results
// o_in_stall rises only while both result entries are full
// synchronous active-low reset empties the queue and idles the parser
`default_nettype none

module radius_attribute_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rap_pkg::t_in_beat  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rap_pkg::t_out_beat      o_out
);

    logic               in_accept;
    logic               res_valid;
    rap_pkg::t_out_beat res;
    logic               push;
    logic               pop;

    logic               r_out_valid,  n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    rap_pkg::t_out_beat r_out,  n_out;
    rap_pkg::t_out_beat r_skid, n_skid;

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;

    rap_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign push = in_accept && res_valid;
    assign pop  = r_out_valid && !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // full: no push is possible
            if (pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (r_out_valid) begin
            if (pop && push) begin
                n_out = res;
            end else if (pop) begin
                n_out_valid = 1'b0;
            end else if (push) begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (push) begin
            n_out       = res;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: sv/rap_checker.sv
// port-level assertions for the radius attribute parser and their bind
`default_nettype none

module rap_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire rap_pkg::t_in_beat  i_in,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire rap_pkg::t_out_beat o_out
);

    // a stalled output beat stays offered
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("output payload changed while stalled");

    // input stalls only when the result queue is full, so a result is on offer
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // without a taken input beat the queue cannot grow from empty
    a_no_invented_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !(i_in_valid && !o_in_stall) |=> !o_out_valid)
        else $error("output beat without an input beat");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("queue not empty after reset");

endmodule

bind radius_attribute_parser rap_checker u_rap_checker (.*);

`default_nettype wire

// File: test/radius_attribute_parser_test.sv
// self-checking testbench for the radius attribute parser
`timescale 1ns / 1ps

module radius_attribute_parser_test;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 75;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_HEADER,
        PS_TYPE,
        PS_LEN,
        PS_VALUE
    } t_parse_state;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    rap_pkg::t_in_beat  i_in        = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    rap_pkg::t_out_beat o_out;

    // parse state mirrored from the block
    t_parse_state ps_state;
    logic [15:0]  ps_offset;
    logic [15:0]  ps_declared;
    logic [6:0]   ps_attr_count;
    logic [7:0]   ps_value_left;
    logic [7:0]   ps_type;
    logic [7:0]   ps_data_len;
    logic         ps_done;

    rap_pkg::t_out_beat expected_fields[$];
    logic [7:0]  packet_bytes[$];
    int          sent_beats  = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    logic        hold_off    = 1'b0;

    radius_attribute_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= hold_off || ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void parse_clear();
        ps_state      = PS_IDLE;
        ps_offset     = '0;
        ps_declared   = '0;
        ps_attr_count = '0;
        ps_value_left = '0;
        ps_type       = '0;
        ps_data_len   = '0;
        ps_done       = 1'b1;
    endfunction

    // runs at an attribute boundary, offset already points at the next byte
    function automatic rap_pkg::t_stop attr_boundary();
        if (ps_offset >= ps_declared) begin
            ps_state = PS_IDLE;
            ps_done  = 1'b1;
            return rap_pkg::STOP_LENGTH;
        end
        if (ps_attr_count >= rap_pkg::MAX_ATTRIBUTES) begin
            ps_state = PS_IDLE;
            ps_done  = 1'b1;
            return rap_pkg::STOP_TOO_MANY;
        end
        ps_state = PS_TYPE;
        return rap_pkg::STOP_RUNNING;
    endfunction

    // returns 1 when the byte produces a result beat
    function automatic bit parse_byte(input rap_pkg::t_in_beat beat,
                                      output rap_pkg::t_out_beat res);
        logic [15:0] pos;
        logic [7:0]  b;
        logic        last;
        b   = beat.byte_value;
        res = '0;
        if (beat.packet_start) begin
            parse_clear();
            ps_state = PS_HEADER;
            ps_done  = 1'b0;
        end else if (ps_done || ps_state == PS_IDLE) begin
            return 1'b0;
        end
        pos = ps_offset;
        if (ps_offset != 16'hFFFF) ps_offset++;
        res.byte_position = pos;
        case (ps_state)
            PS_HEADER: begin
                if (pos == rap_pkg::HEADER_BYTES - 1) res.stop_reason = attr_boundary();
                res.field_value = {8'h00, b};
                if (pos == 16'd0) begin
                    res.kind = rap_pkg::KIND_CODE;
                end else if (pos == 16'd1) begin
                    res.kind = rap_pkg::KIND_IDENTIFIER;
                end else if (pos == 16'd2) begin
                    ps_declared = {b, 8'h00};
                    return 1'b0;
                end else if (pos == 16'd3) begin
                    ps_declared[7:0] = b;
                    res.kind         = rap_pkg::KIND_LENGTH;
                    res.field_value  = ps_declared;
                end else begin
                    res.kind = rap_pkg::KIND_AUTH;
                end
                return 1'b1;
            end
            PS_TYPE: begin
                if (b == 8'h00) begin
                    ps_state        = PS_IDLE;
                    ps_done         = 1'b1;
                    res.kind        = rap_pkg::KIND_ATTR_HDR;
                    res.attr_number = ps_attr_count;
                    res.stop_reason = rap_pkg::STOP_ZERO_TYPE;
                    return 1'b1;
                end
                ps_type  = b;
                ps_state = PS_LEN;
                return 1'b0;
            end
            PS_LEN: begin
                res.malformed_length = (b < rap_pkg::MIN_ATTR_LEN);
                ps_data_len          = res.malformed_length ? 8'd0
                                       : 8'(b - rap_pkg::MIN_ATTR_LEN);
                ps_value_left        = ps_data_len;
                res.kind             = rap_pkg::KIND_ATTR_HDR;
                res.field_value      = {8'h00, b};
                res.attr_number      = ps_attr_count;
                res.attr_kind        = ps_type;
                res.attr_data_length = ps_data_len;
                if (ps_data_len == 8'd0) begin
                    ps_attr_count++;
                    res.stop_reason = attr_boundary();
                end else begin
                    ps_state = PS_VALUE;
                end
                return 1'b1;
            end
            PS_VALUE: begin
                if (ps_value_left != 8'd0) ps_value_left--;
                last                 = (ps_value_left == 8'd0);
                res.kind             = rap_pkg::KIND_ATTR_VALUE;
                res.field_value      = {8'h00, b};
                res.attr_number      = ps_attr_count;
                res.attr_kind        = ps_type;
                res.attr_data_length = ps_data_len;
                res.attr_last_byte   = last;
                if (last) begin
                    ps_attr_count++;
                    res.stop_reason = attr_boundary();
                end
                return 1'b1;
            end
            default: begin
                ps_state = PS_IDLE;
                ps_done  = 1'b1;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin : result_monitor
        rap_pkg::t_out_beat want;
        rap_pkg::t_out_beat predicted;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_fields.size() == 0) begin
                    report_mismatch("unexpected beat, kind", 16'(o_out.kind), 16'hFFFF);
                end else begin
                    want = expected_fields.pop_front();
                    if (o_out.kind !== want.kind)
                        report_mismatch("kind", 16'(o_out.kind), 16'(want.kind));
                    if (o_out.field_value !== want.field_value)
                        report_mismatch("field_value", o_out.field_value, want.field_value);
                    if (o_out.byte_position !== want.byte_position)
                        report_mismatch("byte_position", o_out.byte_position,
                                        want.byte_position);
                    if (o_out.attr_number !== want.attr_number)
                        report_mismatch("attr_number", 16'(o_out.attr_number),
                                        16'(want.attr_number));
                    if (o_out.attr_kind !== want.attr_kind)
                        report_mismatch("attr_kind", 16'(o_out.attr_kind),
                                        16'(want.attr_kind));
                    if (o_out.attr_data_length !== want.attr_data_length)
                        report_mismatch("attr_data_length", 16'(o_out.attr_data_length),
                                        16'(want.attr_data_length));
                    if (o_out.attr_last_byte !== want.attr_last_byte)
                        report_mismatch("attr_last_byte", 16'(o_out.attr_last_byte),
                                        16'(want.attr_last_byte));
                    if (o_out.malformed_length !== want.malformed_length)
                        report_mismatch("malformed_length", 16'(o_out.malformed_length),
                                        16'(want.malformed_length));
                    if (o_out.stop_reason !== want.stop_reason)
                        report_mismatch("stop_reason", 16'(o_out.stop_reason),
                                        16'(want.stop_reason));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                sent_beats++;
                if (parse_byte(i_in, predicted)) expected_fields.push_back(predicted);
            end
        end
    end

    // leaves valid high with the beat just taken; callers send again or drain
    task automatic send_beat(input logic [7:0] value, input logic start);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{byte_value: value, packet_start: start};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_fields.size() != 0) @(posedge i_clk);
    endtask

    task automatic put_header(input logic [7:0] code, input logic [7:0] ident,
                              input logic [15:0] declared);
        packet_bytes.push_back(code);
        packet_bytes.push_back(ident);
        packet_bytes.push_back(declared[15:8]);
        packet_bytes.push_back(declared[7:0]);
        repeat (rap_pkg::HEADER_BYTES - 4) packet_bytes.push_back(8'($urandom));
    endtask

    task automatic put_attr(input logic [7:0] attr_type, input logic [7:0] len_byte);
        packet_bytes.push_back(attr_type);
        packet_bytes.push_back(len_byte);
        if (len_byte >= rap_pkg::MIN_ATTR_LEN)
            repeat (len_byte - rap_pkg::MIN_ATTR_LEN) packet_bytes.push_back(8'($urandom));
    endtask

    task automatic send_packet();
        foreach (packet_bytes[i]) send_beat(packet_bytes[i], i == 0);
        packet_bytes.delete();
    endtask

    task automatic send_random_packet();
        logic [7:0]  body[$];
        logic [7:0]  len_byte;
        logic [15:0] declared;
        int          attr_total;
        int          pick;
        attr_total = ($urandom_range(9) == 0) ? $urandom_range(40, 33) : $urandom_range(6, 0);
        repeat (attr_total) begin
            pick = $urandom_range(99);
            if (pick < 6) len_byte = 8'($urandom_range(1, 0));
            else if (pick < 8) len_byte = 8'd255;
            else if (pick < 16) len_byte = 8'($urandom_range(60, 13));
            else len_byte = 8'($urandom_range(12, 2));
            body.push_back(($urandom_range(24) == 0) ? 8'h00 : 8'($urandom_range(255, 1)));
            body.push_back(len_byte);
            if (len_byte >= rap_pkg::MIN_ATTR_LEN)
                repeat (len_byte - rap_pkg::MIN_ATTR_LEN) body.push_back(8'($urandom));
        end
        pick = $urandom_range(99);
        if (pick < 70) declared = 16'(rap_pkg::HEADER_BYTES + body.size());
        else if (pick < 78) declared = 16'($urandom_range(rap_pkg::HEADER_BYTES, 0));
        else if (pick < 86)
            declared = 16'(rap_pkg::HEADER_BYTES + $urandom_range(body.size(), 0));
        else if (pick < 93) declared = 16'hFFFF;
        else declared = 16'($urandom);
        put_header(8'($urandom), 8'($urandom), declared);
        foreach (body[i]) packet_bytes.push_back(body[i]);
        // broken packet: cut short, the next start restarts the parse
        if ($urandom_range(11) == 0)
            packet_bytes = packet_bytes[0:$urandom_range(packet_bytes.size() - 1, 1) - 1];
        send_packet();
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(4, 1)) send_beat(8'($urandom), 1'b0);
    endtask

    task automatic test_bytes_while_idle();
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h5A, 1'b0);
    endtask

    task automatic test_header_only();
        put_header(8'hFF, 8'h00, 16'd20);
        send_packet();
        send_beat(8'hA5, 1'b0);
        put_header(8'h00, 8'hFF, 16'd0);
        send_packet();
    endtask

    task automatic test_attribute_forms();
        put_header(8'h01, 8'h80, 16'hFFFF);
        put_attr(8'h01, 8'd5);
        put_attr(8'hFF, 8'd0);
        put_attr(8'd26, 8'd1);
        put_attr(8'h02, 8'd255);
        // zero type ends the parse, the byte after it is ignored
        packet_bytes.push_back(8'h00);
        packet_bytes.push_back(8'h07);
        send_packet();
    endtask

    task automatic test_length_stops();
        // value bytes run past the declared length
        put_header(8'h02, 8'h7F, 16'd24);
        put_attr(8'h04, 8'd6);
        send_packet();
        // attribute with empty data closes the packet
        put_header(8'h03, 8'h01, 16'd22);
        put_attr(8'h05, 8'd2);
        send_packet();
    endtask

    task automatic test_attribute_limit();
        put_header(8'h04, 8'h02, 16'hFFFF);
        repeat (rap_pkg::MAX_ATTRIBUTES + 1) put_attr(8'($urandom_range(255, 1)), 8'd2);
        send_packet();
    endtask

    task automatic test_restart_mid_packet();
        put_header(8'h05, 8'h03, 16'd40);
        packet_bytes = packet_bytes[0:9];
        send_packet();
        put_header(8'h06, 8'h04, 16'd20);
        send_packet();
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_stall);
        int target;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        target    = sent_beats + RANDOM_ITEMS;
        while (sent_beats < target) send_random_packet();
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                repeat (2) send_random_packet();
            end
        join
    endtask

    task automatic test_drain_pause();
        idle_pct  = 25;
        stall_pct = 25;
        send_random_packet();
        drain_results();
        send_random_packet();
    endtask

    initial begin
        parse_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bytes_while_idle();
        test_header_only();
        test_attribute_forms();
        test_length_stops();
        test_attribute_limit();
        test_restart_mid_packet();
        test_random_traffic(0, 0);
        test_random_traffic(64, 0);
        test_random_traffic(0, 64);
        test_random_traffic(25, 25);
        test_backpressure();
        test_drain_pause();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
